@@ src/smeu_pkg.sv @@
// smeu_pkg: shared types and constants for the stack machine execute unit
// no dependencies
`timescale 1ns / 1ps
package smeu_pkg;

    localparam logic [7:0] OP_HALT  = 8'hFF;
    localparam logic [7:0] OP_PUSH  = 8'h01;
    localparam logic [7:0] OP_DUP   = 8'h03;
    localparam logic [7:0] OP_ADD   = 8'h10;
    localparam logic [7:0] OP_SUB   = 8'h11;
    localparam logic [7:0] OP_MUL   = 8'h12;
    localparam logic [7:0] OP_DIV   = 8'h13;
    localparam logic [7:0] OP_JMP   = 8'h20;
    localparam logic [7:0] OP_JZ    = 8'h21;
    localparam logic [7:0] OP_JNZ   = 8'h22;
    localparam logic [7:0] OP_STORE = 8'h30;
    localparam logic [7:0] OP_LOAD  = 8'h31;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALT   = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_UNDER  = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;
    localparam logic [2:0] ST_DIVZ   = 3'd5;
    localparam logic [2:0] ST_BADIDX = 3'd6;
    localparam logic [2:0] ST_BADTGT = 3'd7;

    typedef struct packed {
        logic [7:0]         opcode;
        logic signed [31:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [6:0]         stack_depth;
    } out_item_t;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } md_rsp_t;

endpackage

@@ src/smeu_muldiv.sv @@
// smeu_muldiv: shared iterative multiply and truncating divide, one bit per cycle
// depends on smeu_pkg
`timescale 1ns / 1ps
module smeu_muldiv
    import smeu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  md_req_t req,
    output md_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;   // product or remainder
    logic [31:0] q_reg, q_next;       // multiplier shifting out or quotient
    logic [31:0] b_reg, b_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] ma, mb;

    assign ma = req.a[31] ? (32'd0 - req.a) : req.a;
    assign mb = req.b[31] ? (32'd0 - req.b) : req.b;
    assign trial = {acc_reg, q_reg[31]} - {1'b0, b_reg};

    // one step of shift-add multiply or restoring divide
    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            neg_next  = req.a[31] ^ req.b[31];
            cnt_next  = 6'd0;
            acc_next  = 32'd0;
            q_next    = req.is_div ? ma : req.b;
            b_next    = req.is_div ? mb : req.a;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[32])
                begin
                    acc_next = trial[31:0];
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[30:0], q_reg[31]};
                    q_next   = {q_reg[30:0], 1'b0};
                end
            end
            else
            begin
                acc_next = (acc_reg << 1) + (q_reg[31] ? b_reg : 32'd0);
                q_next   = q_reg << 1;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = !div_reg ? acc_reg : (neg_reg ? (32'd0 - q_reg) : q_reg);

endmodule

@@ src/stack_machine_execute_unit.sv @@
// stack_machine_execute_unit: operand stack, data memory and instruction sequencer
// depends on smeu_pkg and smeu_muldiv
// the result is produced through states S_RD1, S_RD2, S_EXEC and S_TOP, with S_MD
// added for mul and div (32 steps in the shared shift-add/restoring unit), and is
// shown in S_OUT; one transaction at a time; reset clears pc, stack pointer and
// halt flag, then a memory clearing pass over all MEM_WORDS words accepts no transaction
`timescale 1ns / 1ps
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int MEM_WORDS   = 256,
    parameter int PC_BITS     = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_RD2   = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_MD    = 8'b0010_0000,
        S_TOP   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] data_mem  [MEM_WORDS];

    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               halt_reg, halt_next;
    logic [MA_W:0]      clr_reg, clr_next;
    in_item_t           item_reg;
    logic [31:0]        b_reg, m_reg;
    logic [2:0]         st_reg, st_next;

    // stack port
    logic              s_we, s_re;
    logic [SA_W-1:0]   s_waddr, s_raddr;
    logic [31:0]       s_wdata, s_rdata;
    // data memory port
    logic              m_we;
    logic [MA_W-1:0]   m_addr;
    logic [31:0]       m_wdata, m_rdata;

    md_req_t md_req;
    md_rsp_t md_rsp;

    smeu_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp));

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        if (s_re)
            s_rdata <= stack_mem[s_raddr];
        if (m_we)
            data_mem[m_addr] <= m_wdata;
        m_rdata <= data_mem[m_addr];
    end

    // decode checks
    logic [7:0]  op;
    logic [31:0] imm;
    logic        idx_bad, tgt_bad, is_imm, taken;
    logic [PC_BITS-1:0] pc_inc;

    assign op      = item_reg.opcode;
    assign imm     = item_reg.immediate;
    assign idx_bad = imm[31] || (imm >= 32'(MEM_WORDS));
    assign tgt_bad = imm[31] || ((imm >> PC_BITS) != 32'd0);
    assign is_imm  = (op == OP_PUSH) || (op == OP_LOAD) || (op == OP_STORE)
                     || (op == OP_JMP) || (op == OP_JZ) || (op == OP_JNZ);
    assign pc_inc  = is_imm ? PC_BITS'(5) : PC_BITS'(1);
    assign taken   = (op == OP_JMP) || ((op == OP_JZ) && (b_reg == 32'd0))
                     || ((op == OP_JNZ) && (b_reg != 32'd0));

    logic needs2, needs1, pushes, fault_under, fault_over;
    assign needs2 = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    assign needs1 = (op == OP_DUP) || (op == OP_STORE) || (op == OP_JZ) || (op == OP_JNZ);
    assign pushes = (op == OP_PUSH) || (op == OP_LOAD) || (op == OP_DUP);
    assign fault_under = (needs2 && sp_reg < SP_W'(2)) || (needs1 && sp_reg == '0);
    assign fault_over  = pushes && (sp_reg == SP_W'(STACK_DEPTH));

    logic known;
    assign known = needs2 || needs1 || pushes || (op == OP_HALT) || (op == OP_JMP);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        clr_next   = clr_reg;
        st_next    = st_reg;
        s_we = 1'b0; s_re = 1'b0;
        s_waddr = '0; s_raddr = '0; s_wdata = '0;
        m_we = 1'b0; m_addr = imm[MA_W-1:0]; m_wdata = '0;
        md_req = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = 1'b1;
                m_addr  = clr_reg[MA_W-1:0];
                clr_next = clr_reg + (MA_W+1)'(1);
                if (clr_reg == (MA_W+1)'(MEM_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_RD1;
            end
            S_RD1:
            begin
                // read top (sp-1); memory read for load already addressed by imm
                s_re    = 1'b1;
                s_raddr = SA_W'(sp_reg - SP_W'(1));
                state_next = S_RD2;
            end
            S_RD2:
            begin
                // read second (sp-2)
                s_re    = 1'b1;
                s_raddr = SA_W'(sp_reg - SP_W'(2));
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // second operand is on the stack read port in this cycle
                state_next = S_TOP;
                st_next    = ST_OK;
                if (halt_reg || op == OP_HALT)
                    st_next = ST_HALT;
                else if (!known)
                    st_next = ST_BADOP;
                else if (fault_under)
                    st_next = ST_UNDER;
                else if (fault_over)
                    st_next = ST_OVER;
                else if ((op == OP_LOAD || op == OP_STORE) && idx_bad)
                    st_next = ST_BADIDX;
                else if (op == OP_DIV && b_reg == 32'd0)
                    st_next = ST_DIVZ;
                else if ((op == OP_JMP || op == OP_JZ || op == OP_JNZ) && taken && tgt_bad)
                    st_next = ST_BADTGT;
                else if (op == OP_MUL || op == OP_DIV)
                begin
                    md_req.start  = 1'b1;
                    md_req.is_div = (op == OP_DIV);
                    md_req.a      = s_rdata;
                    md_req.b      = b_reg;
                    state_next    = S_MD;
                end
                else
                begin
                    pc_next = taken ? imm[PC_BITS-1:0] : pc_reg + pc_inc;
                    priority if (op == OP_PUSH || op == OP_LOAD || op == OP_DUP)
                    begin
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg);
                        s_wdata = (op == OP_PUSH) ? imm : (op == OP_LOAD) ? m_reg : b_reg;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    else if (op == OP_ADD || op == OP_SUB)
                    begin
                        s_we    = 1'b1;
                        s_waddr = SA_W'(sp_reg - SP_W'(2));
                        s_wdata = (op == OP_ADD) ? s_rdata + b_reg : s_rdata - b_reg;
                        sp_next = sp_reg - SP_W'(1);
                    end
                    else if (op == OP_STORE)
                    begin
                        m_we    = 1'b1;
                        m_wdata = b_reg;
                        sp_next = sp_reg - SP_W'(1);
                    end
                    else if (op == OP_JZ || op == OP_JNZ)
                        sp_next = sp_reg - SP_W'(1);
                    else
                        sp_next = sp_reg;
                end
                if (st_next != ST_OK)
                    halt_next = 1'b1;
            end
            S_MD:
            begin
                if (md_rsp.done)
                begin
                    s_we    = 1'b1;
                    s_waddr = SA_W'(sp_reg - SP_W'(2));
                    s_wdata = md_rsp.result;
                    sp_next = sp_reg - SP_W'(1);
                    pc_next = pc_reg + PC_BITS'(1);
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                s_re    = 1'b1;
                s_raddr = SA_W'(sp_reg - SP_W'(1));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sp_reg    <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_data;
        if (state_reg == S_RD2)
        begin
            b_reg <= s_rdata;
            m_reg <= m_rdata;
        end
    end

    // top of stack read in S_TOP holds on the read port through S_OUT
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data.next_pc     = 16'(pc_reg);
    assign out_data.status      = st_reg;
    assign out_data.top_value   = (sp_reg == '0) ? 32'sd0 : signed'(s_rdata);
    assign out_data.stack_depth = 7'(sp_reg);

    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
        else $error("accepting while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && halt_reg) |=> (sp_reg == $past(sp_reg) && pc_reg == $past(pc_reg)))
        else $error("state changed while halted");

endmodule

@@ verif/testbench.sv @@
// testbench: self-checking bench for stack_machine_execute_unit
// depends on smeu_pkg and the execute unit rtl; predicts each result in-line
`timescale 1ns / 1ps
module testbench;
    import smeu_pkg::*;

    localparam int STACK_MAX  = 64;
    localparam int MEM_N      = 256;
    localparam int PC_MAX     = 65535;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 60;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // shadow machine state
    logic [31:0] vm_stack [STACK_MAX];
    logic [31:0] vm_mem [MEM_N];
    int          vm_sp;
    logic [15:0] vm_pc;
    logic        vm_halted;

    out_item_t pending_results [$];
    int        error_count;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        items_sent;
    bit        draining;

    stack_machine_execute_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // truncating signed divide with the most-negative by minus-one wrap
    function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // execute one instruction on the shadow state, return the expected result
    function automatic out_item_t execute_instr(in_item_t it);
        out_item_t   r;
        logic [2:0]  st;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic [31:0] npc;
        logic        bad_idx;
        logic        taken;
        int          sp;
        imm     = it.immediate;
        st      = ST_OK;
        sp      = vm_sp;
        npc     = {16'd0, vm_pc};
        bad_idx = imm[31] || (imm >= MEM_N);
        if (vm_halted)
            st = ST_HALT;
        else
        begin
            case (it.opcode)
                OP_HALT: st = ST_HALT;
                OP_PUSH, OP_LOAD:
                begin
                    if (sp >= STACK_MAX)
                        st = ST_OVER;
                    else if (it.opcode == OP_LOAD && bad_idx)
                        st = ST_BADIDX;
                    else
                    begin
                        vm_stack[sp] = (it.opcode == OP_PUSH) ? imm : vm_mem[imm[7:0]];
                        sp++;
                        npc = vm_pc + 5;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                begin
                    if (sp < 2)
                        st = ST_UNDER;
                    else
                    begin
                        a = vm_stack[sp-2];
                        b = vm_stack[sp-1];
                        if (it.opcode == OP_DIV && b == 32'd0)
                            st = ST_DIVZ;
                        else
                        begin
                            case (it.opcode)
                                OP_ADD:  res = a + b;
                                OP_SUB:  res = a - b;
                                OP_MUL:  res = a * b;
                                default: res = div_toward_zero(a, b);
                            endcase
                            vm_stack[sp-2] = res;
                            sp--;
                            npc = vm_pc + 1;
                        end
                    end
                end
                OP_DUP:
                begin
                    if (sp < 1)
                        st = ST_UNDER;
                    else if (sp >= STACK_MAX)
                        st = ST_OVER;
                    else
                    begin
                        vm_stack[sp] = vm_stack[sp-1];
                        sp++;
                        npc = vm_pc + 1;
                    end
                end
                OP_STORE:
                begin
                    if (sp < 1)
                        st = ST_UNDER;
                    else if (bad_idx)
                        st = ST_BADIDX;
                    else
                    begin
                        sp--;
                        vm_mem[imm[7:0]] = vm_stack[sp];
                        npc = vm_pc + 5;
                    end
                end
                OP_JMP, OP_JZ, OP_JNZ:
                begin
                    taken = 1'b1;
                    if (it.opcode != OP_JMP)
                    begin
                        if (sp < 1)
                            st = ST_UNDER;
                        else if (it.opcode == OP_JZ)
                            taken = (vm_stack[sp-1] == 32'd0);
                        else
                            taken = (vm_stack[sp-1] != 32'd0);
                    end
                    if (st == ST_OK && taken && (imm[31] || imm > PC_MAX))
                        st = ST_BADTGT;
                    if (st == ST_OK)
                    begin
                        if (it.opcode != OP_JMP)
                            sp--;
                        npc = taken ? imm : vm_pc + 5;
                    end
                end
                default: st = ST_BADOP;
            endcase
            if (st != ST_OK)
                vm_halted = 1'b1;
            else
            begin
                vm_sp = sp;
                vm_pc = npc[15:0];
            end
        end
        r.next_pc     = vm_pc;
        r.status      = st;
        r.top_value   = (vm_sp > 0) ? vm_stack[vm_sp-1] : 32'd0;
        r.stack_depth = vm_sp[6:0];
        return r;
    endfunction

    // send one instruction, predict on acceptance
    task automatic send_instr(logic [7:0] op, logic [31:0] imm);
        in_item_t it;
        it.opcode    = op;
        it.immediate = imm;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(execute_instr(it));
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    // one random well-formed instruction that keeps the machine running
    task automatic send_legal_instr();
        int pick;
        bit sent;
        sent = 0;
        while (!sent)
        begin
            pick = $urandom_range(11);
            case (pick)
                0, 1:
                    if (vm_sp < STACK_MAX)
                    begin
                        send_instr(OP_PUSH, rand_word());
                        sent = 1;
                    end
                2:
                    if (vm_sp < STACK_MAX)
                    begin
                        send_instr(OP_LOAD, $urandom_range(MEM_N - 1));
                        sent = 1;
                    end
                3:
                    if (vm_sp > 0)
                    begin
                        send_instr(OP_STORE, $urandom_range(MEM_N - 1));
                        sent = 1;
                    end
                4:
                    if (vm_sp > 0 && vm_sp < STACK_MAX)
                    begin
                        send_instr(OP_DUP, rand_word());
                        sent = 1;
                    end
                5, 6:
                    if (vm_sp >= 2)
                    begin
                        send_instr($urandom_range(1) ? OP_ADD : OP_SUB, rand_word());
                        sent = 1;
                    end
                7:
                    if (vm_sp >= 2)
                    begin
                        send_instr(OP_MUL, rand_word());
                        sent = 1;
                    end
                8:
                    if (vm_sp >= 2 && vm_stack[vm_sp-1] != 32'd0)
                    begin
                        send_instr(OP_DIV, rand_word());
                        sent = 1;
                    end
                9:
                begin
                    send_instr(OP_JMP, $urandom_range(PC_MAX));
                    sent = 1;
                end
                default:
                    if (vm_sp > 0)
                    begin
                        send_instr($urandom_range(1) ? OP_JZ : OP_JNZ,
                                   $urandom_range(PC_MAX));
                        sent = 1;
                    end
            endcase
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, out_data);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_data.next_pc !== exp_r.next_pc)
                begin
                    $display("%0t: next_pc expected %h actual %h",
                             $realtime, exp_r.next_pc, out_data.next_pc);
                    error_count++;
                end
                if (out_data.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, exp_r.status, out_data.status);
                    error_count++;
                end
                if (out_data.top_value !== exp_r.top_value)
                begin
                    $display("%0t: top_value expected %h actual %h",
                             $realtime, exp_r.top_value, out_data.top_value);
                    error_count++;
                end
                if (out_data.stack_depth !== exp_r.stack_depth)
                begin
                    $display("%0t: stack_depth expected %0d actual %0d",
                             $realtime, exp_r.stack_depth, out_data.stack_depth);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT && !draining)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // edge values, every opcode but halt, wrap cases and both jump outcomes
    task automatic test_directed();
        send_instr(OP_PUSH, 32'h7FFF_FFFF);
        send_instr(OP_PUSH, 32'd1);
        send_instr(OP_ADD, 32'd0);
        send_instr(OP_PUSH, 32'h8000_0000);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);
        send_instr(OP_DIV, 32'hFFFF_FFFF);
        send_instr(OP_PUSH, 32'hFFFF_FFFF);
        send_instr(OP_MUL, 32'h8000_0000);
        send_instr(OP_SUB, 32'd0);
        send_instr(OP_DUP, 32'd0);
        send_instr(OP_STORE, 32'd0);
        send_instr(OP_STORE, MEM_N - 1);
        send_instr(OP_LOAD, MEM_N - 1);
        send_instr(OP_LOAD, 32'd0);
        send_instr(OP_PUSH, 32'd0);
        send_instr(OP_JZ, PC_MAX);
        send_instr(OP_PUSH, 32'd1);
        send_instr(OP_JZ, 32'hFFFF_FFFF);
        send_instr(OP_PUSH, 32'd5);
        send_instr(OP_JNZ, 32'd0);
        send_instr(OP_PUSH, 32'd0);
        send_instr(OP_JNZ, 32'h8000_0000);
        send_instr(OP_JMP, 32'd0);
        send_instr(OP_JMP, PC_MAX);
    endtask

    // fill the stack to its limit then drain it into memory
    task automatic test_stack_extremes();
        while (vm_sp < STACK_MAX)
            send_instr(OP_PUSH, $urandom);
        while (vm_sp > 0)
            send_instr(OP_STORE, $urandom_range(MEM_N - 1));
    endtask

    task automatic test_random_programs(int n);
        repeat (n)
            send_legal_instr();
    endtask

    // one fault or halt per run, chosen at random
    task automatic test_terminal_fault();
        logic [7:0] op;
        case ($urandom_range(7))
            0: send_instr(OP_HALT, $urandom);
            1:
            begin
                do
                    op = 8'($urandom);
                while (op inside {OP_HALT, OP_PUSH, OP_DUP, OP_ADD, OP_SUB, OP_MUL,
                                  OP_DIV, OP_JMP, OP_JZ, OP_JNZ, OP_STORE, OP_LOAD});
                send_instr(op, $urandom);
            end
            2:
            begin
                while (vm_sp > 0)
                    send_instr(OP_STORE, $urandom_range(MEM_N - 1));
                send_instr($urandom_range(1) ? OP_ADD : OP_JNZ, $urandom);
            end
            3:
            begin
                while (vm_sp < STACK_MAX)
                    send_instr(OP_PUSH, $urandom);
                send_instr($urandom_range(1) ? OP_DUP : OP_PUSH, $urandom);
            end
            4:
            begin
                if (vm_sp >= STACK_MAX - 1)
                    send_instr(OP_STORE, 32'd3);
                send_instr(OP_PUSH, 32'd0);
                send_instr(OP_DIV, 32'd0);
            end
            5:
            begin
                if (vm_sp == 0)
                    send_instr(OP_PUSH, $urandom);
                send_instr(OP_STORE, $urandom_range(1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF);
            end
            6:
            begin
                if (vm_sp >= STACK_MAX)
                    send_instr(OP_STORE, 32'd7);
                send_instr(OP_LOAD, $urandom_range(1) ? 32'h8000_0000 : MEM_N);
            end
            default: send_instr(OP_JMP, $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_FFFE);
        endcase
    endtask

    // anything sent after the halt must report halt and change nothing
    task automatic test_after_halt();
        repeat (24)
            send_instr(8'($urandom), $urandom);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        draining      = 0;
        vm_sp         = 0;
        vm_pc         = '0;
        vm_halted     = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 57;
        foreach (vm_mem[i])
            vm_mem[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_programs(400);
        test_stack_extremes();
        send_idle_pct = 57;
        recv_idle_pct = 13;
        test_random_programs(400);
        test_stack_extremes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_programs(230);
        test_terminal_fault();
        test_after_halt();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        draining = 1;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
